>>> rtl/bmcw_pkg.sv
// Package for the body move, collide and wrap engine.
// Item, result and table entry types, function codes, fixed-point helpers.
// No dependencies.
`timescale 1ns / 1ps

package bmcw_pkg;

  localparam int unsigned BODY_COUNT_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 8;
  localparam int unsigned IDX_W          = 4;
  localparam int unsigned POS_W          = 24;
  localparam int unsigned EXT_W          = 23;
  localparam int unsigned SCR_W          = 15;
  localparam int unsigned SW             = 27;
  localparam logic [POS_W-1:0] POS_MAX   = 24'h7FFFFF;
  localparam logic [POS_W-1:0] POS_MIN   = 24'h800000;
  localparam logic [SCR_W-1:0] SCR_W_RST = 15'd640;
  localparam logic [SCR_W-1:0] SCR_H_RST = 15'd480;

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_MOVE = 2'd1,
    FUNC_VEL  = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SCAN,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    func_e                   func;
    logic [IDX_W-1:0]        body_index;
    logic                    shape_kind;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [EXT_W-1:0]        extent_x;
    logic [EXT_W-1:0]        extent_y;
    logic signed [POS_W-1:0] motion_x;
    logic signed [POS_W-1:0] motion_y;
    logic                    wrap_enable;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]        done_index;
    logic signed [POS_W-1:0] new_pos_x;
    logic signed [POS_W-1:0] new_pos_y;
    logic                    blocked;
    logic [IDX_W-1:0]        hit_index;
  } out_t;

  typedef struct packed {
    logic                    kind;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [EXT_W-1:0]        ext_x;
    logic [EXT_W-1:0]        ext_y;
  } geom_t;

  typedef struct packed {
    geom_t                   g;
    logic signed [POS_W-1:0] vel_x;
    logic signed [POS_W-1:0] vel_y;
  } entry_t;

  typedef struct packed {
    logic issue;
    logic cand;
  } probe_t;

  function automatic logic signed [POS_W-1:0] sat_add(
    input logic signed [POS_W-1:0] a,
    input logic signed [POS_W-1:0] b
  );
    logic signed [POS_W:0] s;
    s = {a[POS_W-1], a} + {b[POS_W-1], b};
    if (s[POS_W] != s[POS_W-1]) begin
      sat_add = s[POS_W] ? POS_MIN : POS_MAX;
    end else begin
      sat_add = s[POS_W-1:0];
    end
  endfunction

  function automatic logic signed [SW-1:0] sx(input logic signed [POS_W-1:0] p);
    sx = SW'(p);
  endfunction

  function automatic logic signed [SW-1:0] ux(input logic [EXT_W-1:0] e);
    ux = $signed({{(SW-EXT_W){1'b0}}, e});
  endfunction

  function automatic logic signed [POS_W-1:0] wrap_axis(
    input logic signed [POS_W-1:0] p,
    input logic [POS_W-1:0]        lim
  );
    if ($signed({p[POS_W-1], p}) > $signed({1'b0, lim})) begin
      wrap_axis = '0;
    end else if (p[POS_W-1]) begin
      wrap_axis = $signed(lim);
    end else begin
      wrap_axis = p;
    end
  endfunction

endpackage

>>> rtl/bmcw_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module bmcw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> rtl/bmcw_collide.sv
// Collision test pipeline: one table entry per cycle against the moved body.
// Stage A differences and compares, stage B squares, then the final decision.
// Depends on bmcw_pkg.
`timescale 1ns / 1ps

module bmcw_collide import bmcw_pkg::*; #(
  parameter int unsigned AW = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  probe_t        probe_i,
  input  logic [AW-1:0] k_i,
  input  geom_t         mover_i,
  input  geom_t         other_i,
  output logic          busy_o,
  output logic          hit_o,
  output logic [AW-1:0] hit_k_o
);

  logic                 p0_q, cand0_q;
  logic [AW-1:0]        k0_q, ka_q, kb_q;
  logic                 va_q, vb_q;
  logic                 prea_q, needa_q, preb_q, needb_q;
  logic signed [SW-1:0] dxa_d, dxb_d, dya_d, dyb_d, rr_d;
  logic signed [SW-1:0] dxa_q, dxb_q, dya_q, dyb_q, rr_q;
  logic                 pre_d, need_d;
  logic signed [2*SW-1:0] sxa_q, sxb_q, sya_q, syb_q, r2_q;
  logic signed [2*SW:0]   d00, d10, d01, d11, r2x;

  logic signed [SW-1:0] ax, ay, aw, ah, ox, oy, ow, oh;
  logic signed [SW-1:0] bx, by, bw, bh, cx, cy, cr;
  logic                 same, bbov, cbov, span;

  always_comb begin
    ax = sx(mover_i.pos_x);
    ay = sx(mover_i.pos_y);
    aw = ux(mover_i.ext_x);
    ah = ux(mover_i.ext_y);
    ox = sx(other_i.pos_x);
    oy = sx(other_i.pos_y);
    ow = ux(other_i.ext_x);
    oh = ux(other_i.ext_y);
    same = (mover_i.kind == other_i.kind);
    if (!mover_i.kind) begin
      bx = ax; by = ay; bw = aw; bh = ah;
      cx = ox; cy = oy; cr = ow;
    end else begin
      bx = ox; by = oy; bw = ow; bh = oh;
      cx = ax; cy = ay; cr = aw;
    end
    bbov = (ay < oy + oh) && (ay + ah > oy) && (ax < ox + ow) && (ax + aw > ox);
    cbov = (by < cy + cr) && (by + bh > cy - cr) && (bx < cx + cr) && (bx + bw > cx - cr);
    span = ((cx > bx) && (cx < bx + bw)) || ((cy > by) && (cy < by + bh));
    if (same) begin
      dxa_d  = ax - ox;
      dxb_d  = ax - ox;
      dya_d  = ay - oy;
      dyb_d  = ay - oy;
      rr_d   = aw + ow;
      pre_d  = !mover_i.kind && bbov;
      need_d = mover_i.kind;
    end else begin
      dxa_d  = bx - cx;
      dxb_d  = bx + bw - cx;
      dya_d  = by - cy;
      dyb_d  = by + bh - cy;
      rr_d   = cr;
      pre_d  = cbov && span;
      need_d = cbov && !span;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_q <= 1'b0;
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      p0_q <= probe_i.issue;
      va_q <= p0_q && cand0_q;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cand0_q <= probe_i.cand;
    k0_q    <= k_i;
    ka_q    <= k0_q;
    prea_q  <= pre_d;
    needa_q <= need_d;
    dxa_q   <= dxa_d;
    dxb_q   <= dxb_d;
    dya_q   <= dya_d;
    dyb_q   <= dyb_d;
    rr_q    <= rr_d;
    kb_q    <= ka_q;
    preb_q  <= prea_q;
    needb_q <= needa_q;
    sxa_q   <= dxa_q * dxa_q;
    sxb_q   <= dxb_q * dxb_q;
    sya_q   <= dya_q * dya_q;
    syb_q   <= dyb_q * dyb_q;
    r2_q    <= rr_q * rr_q;
  end

  assign d00 = (2*SW+1)'(sxa_q) + (2*SW+1)'(sya_q);
  assign d10 = (2*SW+1)'(sxb_q) + (2*SW+1)'(sya_q);
  assign d01 = (2*SW+1)'(sxa_q) + (2*SW+1)'(syb_q);
  assign d11 = (2*SW+1)'(sxb_q) + (2*SW+1)'(syb_q);
  assign r2x = (2*SW+1)'(r2_q);

  assign hit_o   = vb_q && (preb_q ||
                   (needb_q && ((d00 < r2x) || (d10 < r2x) || (d01 < r2x) || (d11 < r2x))));
  assign hit_k_o = kb_q;
  assign busy_o  = p0_q || va_q || vb_q;

endmodule

>>> rtl/body_move_collide_wrap_engine.sv
// Body move, collide and wrap engine: top level with the item sequencer.
// Depends on bmcw_pkg, bmcw_ram and bmcw_collide.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------
//   item     | start / busy           | item_i   (in_t)
//   result   | done_o (one cycle)     | result_o (out_t)
//   config   | cfg_we_i, cfg_idx_i    | cfg_wdata_i (15 bits)
//
// A load, or any item with an index beyond the table, finishes in the cycle it
// is accepted; its result is registered and shows in the next. A move reads the
// moved body's entry, then reads each table entry in turn through the collision
// pipeline, lets it drain and writes back. Reset clears the valid bits at once.
// Results cannot be held off; done_o is high for exactly one cycle per item.
`timescale 1ns / 1ps

module body_move_collide_wrap_engine import bmcw_pkg::*; #(
  parameter int unsigned BODY_COUNT = BODY_COUNT_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  in_t              item_i,
  input  logic             cfg_we_i,
  input  cfg_e             cfg_idx_i,
  input  logic [SCR_W-1:0] cfg_wdata_i,
  output logic             done_o,
  output out_t             result_o
);

  localparam int unsigned AW = $clog2(BODY_COUNT);
  localparam int unsigned CW = ((AW > IDX_W) ? AW : IDX_W) + 1;

  state_e            state_q, state_d;
  in_t               req_q, req_d;
  entry_t            entry_q, entry_d;
  geom_t             mover_q, mover_d;
  logic [AW-1:0]     k_q, k_d;
  logic              found_q, found_d;
  logic [AW-1:0]     hitk_q, hitk_d;
  logic [BODY_COUNT-1:0] valid_q, valid_d;
  logic [SCR_W-1:0]  scr_w_q, scr_h_q;
  out_t              res_q, res_d;
  logic              done_q, done_d;

  logic              accept, idx_ok;
  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  entry_t            wdata, rdata;
  probe_t            probe;
  logic              pipe_busy, hit;
  logic [AW-1:0]     hit_k;
  logic [AW-1:0]     idx_a, req_a;
  logic signed [POS_W-1:0] mx, my, fx, fy;
  logic [POS_W-1:0]  lim_w, lim_h;
  logic [31:0]       sw32, sh32;

  assign accept = start && !busy;
  assign idx_a  = AW'(item_i.body_index);
  assign req_a  = AW'(req_q.body_index);
  assign idx_ok = CW'(item_i.body_index) < CW'(BODY_COUNT);

  assign sw32  = 32'(scr_w_q) << FRAC_BITS;
  assign sh32  = 32'(scr_h_q) << FRAC_BITS;
  assign lim_w = (sw32 > 32'(POS_MAX)) ? POS_MAX : sw32[POS_W-1:0];
  assign lim_h = (sh32 > 32'(POS_MAX)) ? POS_MAX : sh32[POS_W-1:0];

  bmcw_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (BODY_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  bmcw_collide #(
    .AW (AW)
  ) u_collide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .probe_i (probe),
    .k_i     (k_q),
    .mover_i (mover_q),
    .other_i (rdata.g),
    .busy_o  (pipe_busy),
    .hit_o   (hit),
    .hit_k_o (hit_k)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && idx_ok && (item_i.func != FUNC_LOAD)) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if ((req_q.func == FUNC_NONE) || !valid_q[req_a]) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (k_q == AW'(BODY_COUNT - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_d   = req_q;
    entry_d = entry_q;
    mover_d = mover_q;
    k_d     = k_q;
    found_d = found_q;
    hitk_d  = hitk_q;
    valid_d = valid_q;
    res_d   = res_q;
    done_d  = 1'b0;
    we      = 1'b0;
    re      = 1'b0;
    waddr   = idx_a;
    raddr   = idx_a;
    wdata   = entry_q;
    probe   = '0;
    mx      = (req_q.func == FUNC_MOVE) ? req_q.motion_x : rdata.vel_x;
    my      = (req_q.func == FUNC_MOVE) ? req_q.motion_y : rdata.vel_y;
    fx      = found_q ? entry_q.g.pos_x : mover_q.pos_x;
    fy      = found_q ? entry_q.g.pos_y : mover_q.pos_y;
    if (req_q.wrap_enable) begin
      fx = wrap_axis(fx, lim_w);
      fy = wrap_axis(fy, lim_h);
    end
    if (hit && !found_q) begin
      found_d = 1'b1;
      hitk_d  = hit_k;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_d  = item_i;
          res_d  = '0;
          res_d.done_index = item_i.body_index;
          if (!idx_ok) begin
            done_d = 1'b1;
          end else if (item_i.func == FUNC_LOAD) begin
            we       = 1'b1;
            wdata.g.kind  = item_i.shape_kind;
            wdata.g.pos_x = item_i.pos_x;
            wdata.g.pos_y = item_i.pos_y;
            wdata.g.ext_x = item_i.extent_x;
            wdata.g.ext_y = item_i.extent_y;
            wdata.vel_x   = item_i.motion_x;
            wdata.vel_y   = item_i.motion_y;
            valid_d[idx_a] = 1'b1;
            res_d.new_pos_x = item_i.pos_x;
            res_d.new_pos_y = item_i.pos_y;
            done_d = 1'b1;
          end else begin
            re = 1'b1;
          end
        end
      end
      ST_FETCH: begin
        entry_d       = rdata;
        mover_d       = rdata.g;
        mover_d.pos_x = sat_add(rdata.g.pos_x, mx);
        mover_d.pos_y = sat_add(rdata.g.pos_y, my);
        k_d           = '0;
        found_d       = 1'b0;
        hitk_d        = '0;
        if ((req_q.func == FUNC_NONE) || !valid_q[req_a]) begin
          res_d.new_pos_x = rdata.g.pos_x;
          res_d.new_pos_y = rdata.g.pos_y;
          done_d = 1'b1;
        end
      end
      ST_SCAN: begin
        re          = 1'b1;
        raddr       = k_q;
        probe.issue = 1'b1;
        probe.cand  = valid_q[k_q] && (k_q != req_a);
        k_d         = k_q + AW'(1);
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          we            = 1'b1;
          waddr         = req_a;
          wdata         = entry_q;
          wdata.g.pos_x = fx;
          wdata.g.pos_y = fy;
          res_d.new_pos_x = fx;
          res_d.new_pos_y = fy;
          res_d.blocked   = found_q;
          res_d.hit_index = IDX_W'(hitk_q);
          done_d = 1'b1;
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= '0;
      done_q  <= 1'b0;
      found_q <= 1'b0;
      scr_w_q <= SCR_W_RST;
      scr_h_q <= SCR_H_RST;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      done_q  <= done_d;
      found_q <= found_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_WIDTH:  scr_w_q <= cfg_wdata_i;
          CFG_HEIGHT: scr_h_q <= cfg_wdata_i;
          default:    scr_w_q <= scr_w_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    entry_q <= entry_d;
    mover_q <= mover_d;
    k_q     <= k_d;
    hitk_q  <= hitk_d;
    res_q   <= res_d;
  end

  assign busy     = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

>>> rtl/bmcw_checker.sv
// Port-level checks for the body move, collide and wrap engine, with bind.
// Depends on bmcw_pkg and the top level.
`timescale 1ns / 1ps

module bmcw_checker import bmcw_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input out_t result_o
);

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || done_o)
    else $error("accepted item neither busy nor done");

  a_done_follows_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy) || $past(start))
    else $error("result without an item");

  a_no_self_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.blocked |-> result_o.hit_index != result_o.done_index)
    else $error("body reported hitting itself");

  a_hit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !result_o.blocked |-> result_o.hit_index == '0)
    else $error("hit index set without block");

endmodule

bind body_move_collide_wrap_engine bmcw_checker u_bmcw_checker (.*);
